// ===== rtl/core/mcvg_pkg.sv =====
package mcvg_pkg;

    // Chord table geometry
    localparam int KIND_COUNT        = 21;
    localparam int TABLE_WIDTH       = 7;
    localparam int OFFSET_W          = 5;
    localparam int TONE_W            = 6;
    localparam int NOTE_W            = 7;
    localparam int TONE_INDEX_W      = 3;
    localparam int DEFAULT_MAX_TONES = 7;

    // Stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef logic [TABLE_WIDTH*OFFSET_W-1:0] kind_row_t;
    typedef logic [NOTE_W-1:0]               note_t;
    typedef logic [TONE_W-1:0]               tone_t;

    // Quality codes in table order
    typedef enum logic [4:0] {
        KIND_MAJOR     = 5'd0,
        KIND_MINOR     = 5'd1,
        KIND_DIM       = 5'd2,
        KIND_AUG       = 5'd3,
        KIND_SUS2      = 5'd4,
        KIND_SUS4      = 5'd5,
        KIND_MAJ7      = 5'd6,
        KIND_MIN7      = 5'd7,
        KIND_DOM7      = 5'd8,
        KIND_DIM7      = 5'd9,
        KIND_HALF_DIM  = 5'd10,
        KIND_MAJ6      = 5'd11,
        KIND_MIN6      = 5'd12,
        KIND_ADD9      = 5'd13,
        KIND_DOM9      = 5'd14,
        KIND_DOM11     = 5'd15,
        KIND_DOM13     = 5'd16,
        KIND_7B9       = 5'd17,
        KIND_7S9       = 5'd18,
        KIND_7S11      = 5'd19,
        KIND_7B13      = 5'd20
    } chord_kind_t;

    // Number of tones of a quality; zero for an unknown code
    function automatic logic [2:0] kind_size(input logic [4:0] kind);
        logic [2:0] size;
        case (kind)
            KIND_MAJOR, KIND_MINOR, KIND_DIM,
            KIND_AUG, KIND_SUS2, KIND_SUS4:        size = 3'd3;
            KIND_MAJ7, KIND_MIN7, KIND_DOM7, KIND_DIM7, KIND_HALF_DIM,
            KIND_MAJ6, KIND_MIN6, KIND_ADD9:       size = 3'd4;
            KIND_DOM9, KIND_7B9, KIND_7S9:         size = 3'd5;
            KIND_DOM11, KIND_7S11:                 size = 3'd6;
            KIND_DOM13, KIND_7B13:                 size = 3'd7;
            default:                               size = 3'd0;
        endcase
        return size;
    endfunction

    // Semitone offsets of a quality, entry 0 in the lowest bits
    function automatic kind_row_t kind_row(input logic [4:0] kind);
        kind_row_t row;
        case (kind)
            KIND_MAJOR:    row = {5'd0, 5'd0, 5'd0, 5'd0, 5'd7, 5'd4, 5'd0};
            KIND_MINOR:    row = {5'd0, 5'd0, 5'd0, 5'd0, 5'd7, 5'd3, 5'd0};
            KIND_DIM:      row = {5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd3, 5'd0};
            KIND_AUG:      row = {5'd0, 5'd0, 5'd0, 5'd0, 5'd8, 5'd4, 5'd0};
            KIND_SUS2:     row = {5'd0, 5'd0, 5'd0, 5'd0, 5'd7, 5'd2, 5'd0};
            KIND_SUS4:     row = {5'd0, 5'd0, 5'd0, 5'd0, 5'd7, 5'd5, 5'd0};
            KIND_MAJ7:     row = {5'd0, 5'd0, 5'd0, 5'd11, 5'd7, 5'd4, 5'd0};
            KIND_MIN7:     row = {5'd0, 5'd0, 5'd0, 5'd10, 5'd7, 5'd3, 5'd0};
            KIND_DOM7:     row = {5'd0, 5'd0, 5'd0, 5'd10, 5'd7, 5'd4, 5'd0};
            KIND_DIM7:     row = {5'd0, 5'd0, 5'd0, 5'd9, 5'd6, 5'd3, 5'd0};
            KIND_HALF_DIM: row = {5'd0, 5'd0, 5'd0, 5'd10, 5'd6, 5'd3, 5'd0};
            KIND_MAJ6:     row = {5'd0, 5'd0, 5'd0, 5'd9, 5'd7, 5'd4, 5'd0};
            KIND_MIN6:     row = {5'd0, 5'd0, 5'd0, 5'd9, 5'd7, 5'd3, 5'd0};
            KIND_ADD9:     row = {5'd0, 5'd0, 5'd0, 5'd14, 5'd7, 5'd4, 5'd0};
            KIND_DOM9:     row = {5'd0, 5'd0, 5'd14, 5'd10, 5'd7, 5'd4, 5'd0};
            KIND_DOM11:    row = {5'd0, 5'd17, 5'd14, 5'd10, 5'd7, 5'd4, 5'd0};
            KIND_DOM13:    row = {5'd21, 5'd17, 5'd14, 5'd10, 5'd7, 5'd4, 5'd0};
            KIND_7B9:      row = {5'd0, 5'd0, 5'd13, 5'd10, 5'd7, 5'd4, 5'd0};
            KIND_7S9:      row = {5'd0, 5'd0, 5'd15, 5'd10, 5'd7, 5'd4, 5'd0};
            KIND_7S11:     row = {5'd0, 5'd18, 5'd14, 5'd10, 5'd7, 5'd4, 5'd0};
            KIND_7B13:     row = {5'd20, 5'd17, 5'd14, 5'd10, 5'd7, 5'd4, 5'd0};
            default:       row = '0;
        endcase
        return row;
    endfunction

    // Root modulo 12 with negative wrap: bias by 132, then divide by
    // reciprocal (683 / 8192) which is exact for values up to 259
    function automatic logic [3:0] root_mod12(input logic [7:0] root);
        logic [8:0]  biased;
        logic [18:0] prod;
        logic [5:0]  quot;
        logic [8:0]  rem;
        biased = {root[7], root} + 9'd132;
        prod   = 19'(biased) * 19'd683;
        quot   = prod[18:13];
        rem    = biased - 9'(quot) * 9'd12;
        return rem[3:0];
    endfunction

    // (clamped octave + 1) * 12
    function automatic note_t octave_base(input logic [4:0] octave);
        note_t base;
        if ($signed(octave) < 5'sd2)
        begin
            base = 7'd36;
        end
        else if ($signed(octave) > 5'sd6)
        begin
            base = 7'd84;
        end
        else
        begin
            case (octave[2:0])
                3'd2:    base = 7'd36;
                3'd3:    base = 7'd48;
                3'd4:    base = 7'd60;
                3'd5:    base = 7'd72;
                3'd6:    base = 7'd84;
                default: base = 7'd36;
            endcase
        end
        return base;
    endfunction

endpackage

// ===== rtl/core/midi_chord_voicing_generator_unit.sv =====
// MIDI chord voicing generator.
// Input channel (s_axis_*): one chord per transfer, carrying root, quality
// code, inversion count and octave. Output channel (m_axis_*): one transfer
// per chord tone in ascending pitch order, tlast on the highest tone.
// Unknown quality codes are consumed and produce no output transfers.
// The first tone is offered on m_axis once the chord has passed through the
// chord register and then the output register.
// Throughput: one output transfer per cycle while the receiver is ready; a
// chord holds 3 to 7 tones. The chord register takes the next chord in the
// same cycle its final tone moves into the output register, and an unknown
// code leaves the chord register empty.
// Voicing (root reduction, octave clamp, inversion and re-sort) is done in
// one pass of logic ahead of the chord register.
// Reset clears the chord and output valid flags; no chord is held.
// When the receiver stalls, the output register holds its tone, the chord
// register holds the rest and s_axis_tready drops until the final tone of
// the held chord has moved on.
module midi_chord_voicing_generator_unit #(
    parameter int MAX_TONES = mcvg_pkg::DEFAULT_MAX_TONES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] root_value, [12:8] chord_kind, [17:13] inversion_count,
    // [22:18] octave_number, [23] zero
    input  logic [mcvg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [6:0] midi_note, [9:7] tone_index, [15:10] zero
    output logic [mcvg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_TONES + 1);
    localparam int IDX_W = $clog2(MAX_TONES);

    // Input fields
    logic [7:0] root_value;
    logic [4:0] chord_kind;
    logic [4:0] inversion_count;
    logic [4:0] octave_number;

    assign root_value      = s_axis_tdata[7:0];
    assign chord_kind      = s_axis_tdata[12:8];
    assign inversion_count = s_axis_tdata[17:13];
    assign octave_number   = s_axis_tdata[22:18];

    // Voicing logic
    logic [CNT_W-1:0]     count_in;
    mcvg_pkg::note_t      base_in;
    mcvg_pkg::kind_row_t  row_in;
    logic                 invert_in;
    mcvg_pkg::tone_t      raw_tone [MAX_TONES];
    logic [IDX_W-1:0]     rank     [MAX_TONES];
    mcvg_pkg::tone_t      sorted   [MAX_TONES];
    mcvg_pkg::note_t      notes_in [MAX_TONES];

    // Chord register
    logic                 chord_valid_reg, chord_valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    mcvg_pkg::note_t      notes_reg [MAX_TONES];

    // Output register
    logic                 out_valid_reg, out_valid_next;
    mcvg_pkg::note_t      out_note_reg;
    logic [mcvg_pkg::TONE_INDEX_W-1:0] out_index_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 tone_move;
    logic                 final_move;
    logic                 in_xfer;

    // Base note, chord size, offset row and inversion flag
    always_comb
    begin
        count_in  = CNT_W'(mcvg_pkg::kind_size(chord_kind));
        base_in   = mcvg_pkg::octave_base(octave_number)
                  + mcvg_pkg::note_t'(mcvg_pkg::root_mod12(root_value));
        row_in    = mcvg_pkg::kind_row(chord_kind);
        invert_in = !inversion_count[4] && (inversion_count != 5'd0)
                  && ({1'b0, inversion_count[3:0]} < 5'(count_in));
    end

    // Raise the lowest offsets an octave
    always_comb
    begin
        for (int i = 0; i < MAX_TONES; i++)
        begin
            if (i < mcvg_pkg::TABLE_WIDTH)
            begin
                raw_tone[i] = mcvg_pkg::tone_t'(row_in[i*mcvg_pkg::OFFSET_W +: mcvg_pkg::OFFSET_W]);
            end
            else
            begin
                raw_tone[i] = '0;
            end
            if (invert_in && (5'(i) < {1'b0, inversion_count[3:0]}))
            begin
                raw_tone[i] = raw_tone[i] + mcvg_pkg::tone_t'(12);
            end
        end
    end

    // Rank each tone against the others, ties broken by position
    always_comb
    begin
        for (int i = 0; i < MAX_TONES; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < MAX_TONES; j++)
            begin
                if ((j != i) && (CNT_W'(j) < count_in)
                    && ((raw_tone[j] < raw_tone[i])
                        || ((raw_tone[j] == raw_tone[i]) && (j < i))))
                begin
                    rank[i] = rank[i] + IDX_W'(1);
                end
            end
        end
    end

    // Place each tone at its rank and add the base note
    always_comb
    begin
        for (int p = 0; p < MAX_TONES; p++)
        begin
            sorted[p] = '0;
            for (int i = 0; i < MAX_TONES; i++)
            begin
                if ((CNT_W'(i) < count_in) && (rank[i] == IDX_W'(p)))
                begin
                    sorted[p] = sorted[p] | raw_tone[i];
                end
            end
            notes_in[p] = base_in + mcvg_pkg::note_t'(sorted[p]);
        end
    end

    // Handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign tone_move     = chord_valid_reg && out_free;
    assign final_move    = tone_move && (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign s_axis_tready = !chord_valid_reg || final_move;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Chord register control: load on transfer, advance per tone
    always_comb
    begin
        chord_valid_next = chord_valid_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        if (in_xfer)
        begin
            chord_valid_next = (count_in != '0);
            count_next       = count_in;
            idx_next         = '0;
        end
        else if (final_move)
        begin
            chord_valid_next = 1'b0;
            idx_next         = '0;
        end
        else if (tone_move)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // Output valid: fill on tone move, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tone_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chord_valid_reg <= 1'b0;
            count_reg       <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            chord_valid_reg <= chord_valid_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int p = 0; p < MAX_TONES; p++)
            begin
                notes_reg[p] <= notes_in[p];
            end
        end
        if (tone_move)
        begin
            out_note_reg  <= notes_reg[idx_reg];
            out_index_reg <= mcvg_pkg::TONE_INDEX_W'(idx_reg);
            out_last_reg  <= (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {
        (mcvg_pkg::OUT_DATA_W - mcvg_pkg::NOTE_W - mcvg_pkg::TONE_INDEX_W)'(0),
        out_index_reg,
        out_note_reg
    };

endmodule
